// ===== rtl/core/stok_pkg.sv =====
// Shared types, codes and keyword tables for the script tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package stok_pkg;

    localparam int unsigned MAX_RES = 4;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned NUM_KW = 8;

    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_COMMENT = 3'd1;
    localparam logic [2:0] MODE_NUMBER  = 3'd2;
    localparam logic [2:0] MODE_IDENT   = 3'd3;
    localparam logic [2:0] MODE_STRING  = 3'd4;

    localparam logic [1:0] EV_OPEN  = 2'd0;
    localparam logic [1:0] EV_CHAR  = 2'd1;
    localparam logic [1:0] EV_CLOSE = 2'd2;
    localparam logic [1:0] EV_EOF   = 2'd3;

    localparam logic [2:0] CLS_NUMBER  = 3'd0;
    localparam logic [2:0] CLS_IDENT   = 3'd1;
    localparam logic [2:0] CLS_KEYWORD = 3'd2;
    localparam logic [2:0] CLS_STRING  = 3'd3;
    localparam logic [2:0] CLS_OPER    = 3'd4;
    localparam logic [2:0] CLS_PUNCT   = 3'd5;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_UNDER   = 8'h5F;

    localparam logic [3:0] LEN_MAX = 4'd15;

    // Keyword text, right aligned: the first letter sits in the highest used byte.
    localparam logic [79:0] KW_TEXT [NUM_KW] = '{
        80'("let"), 80'("drawText"), 80'("drawCircle"), 80'("drawLine"),
        80'("sin"), 80'("cos"), 80'("tan"), 80'("sqrt")
    };
    localparam logic [3:0] KW_LEN [NUM_KW] = '{
        4'd3, 4'd8, 4'd10, 4'd8, 4'd3, 4'd3, 4'd3, 4'd4
    };

    typedef struct packed {
        logic       kind;
        logic [7:0] char_code;
    } t_in_item;

    typedef struct packed {
        logic [1:0] event_res;
        logic [2:0] token_class;
        logic [7:0] out_char;
        logic [3:0] keyword_id;
        logic       last_of_run;
    } t_out_item;

    typedef struct packed {
        logic [1:0]                  last_idx;
        t_out_item [MAX_RES-1:0]     res;
    } t_bundle;

    function automatic t_out_item mk_res(input logic [1:0] ev, input logic [2:0] cls,
                                         input logic [7:0] ch, input logic [3:0] kw);
        t_out_item r;
        r.event_res   = ev;
        r.token_class = cls;
        r.out_char    = ch;
        r.keyword_id  = kw;
        r.last_of_run = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/script_tokenizer.sv =====
// Top level of the streaming script tokenizer.
// With the output register free, the first result of an item passes the bundle queue and then the output register.
// Throughput: one input byte per cycle while each byte yields at most one result and i_out_ready
// is high; the output register sends one result per cycle while ready, each result of a byte in turn.
// A four-entry bundle queue lets the input keep moving during multi-result bursts.
// Reset is synchronous and active low; the scan state returns to idle between tokens.
`timescale 1ns / 1ps
`default_nettype none

module script_tokenizer (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire stok_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output stok_pkg::t_out_item      o_out_item
);
    import stok_pkg::*;

    logic    push, pop, full, empty;
    t_bundle bundle, head;

    assign o_in_ready = !full;

    stok_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (i_in_valid && o_in_ready),
        .i_item   (i_in_item),
        .o_push   (push),
        .o_bundle (bundle)
    );

    stok_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (bundle),
        .i_pop    (pop),
        .o_full   (full),
        .o_empty  (empty),
        .o_head   (head)
    );

    stok_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_head      (head),
        .o_pop       (pop),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

// ===== rtl/core/stok_front.sv =====
// Front end: classifies each byte or end-of-file item, updates the scan state and builds a result bundle.
`timescale 1ns / 1ps
`default_nettype none

module stok_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire stok_pkg::t_in_item i_item,
    output logic                   o_push,
    output stok_pkg::t_bundle      o_bundle
);
    import stok_pkg::*;

    logic [2:0] r_mode, n_mode;
    logic       r_dot, n_dot;
    logic [7:0] r_cand, n_cand;
    logic [3:0] r_len, n_len;

    logic [7:0] c;
    logic       c_digit, c_alpha, c_space, c_word, c_oper;
    logic [7:0] cand_tr, cand_first;
    logic [3:0] len_inc;
    logic [3:0] kw_id;
    logic [2:0] cnt;
    logic       do_char, do_close, do_idle;
    t_out_item [MAX_RES-1:0] res;

    function automatic logic kw_step(input int unsigned k, input logic [3:0] pos,
                                     input logic [7:0] ch);
        logic [3:0] len;
        logic [3:0] idx;
        len = KW_LEN[k];
        idx = len - 4'd1 - pos;
        return (pos < len) && (KW_TEXT[k][{idx, 3'b000} +: 8] == ch);
    endfunction

    assign c       = i_item.char_code;
    assign c_digit = (c >= "0") && (c <= "9");
    assign c_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    assign c_space = (c == 8'h20) || ((c >= 8'd9) && (c <= 8'd13));
    assign c_word  = c_alpha || c_digit || (c == CH_UNDER) || (c == CH_DOLLAR);
    assign c_oper  = c inside {"+", "-", "*", "/", "=", "(", ")", ",", "%"};
    assign len_inc = (r_len == LEN_MAX) ? LEN_MAX : r_len + 4'd1;

    always_comb begin
        for (int k = 0; k < NUM_KW; k++) begin
            cand_tr[k]    = r_cand[k] & kw_step(k, r_len, c);
            cand_first[k] = kw_step(k, 4'd0, c);
        end
    end

    always_comb begin
        kw_id = 4'd0;
        for (int k = NUM_KW - 1; k >= 0; k--) begin
            if (r_cand[k] && (KW_LEN[k] == r_len)) begin
                kw_id = 4'(k + 1);
            end
        end
    end

    always_comb begin
        n_mode   = r_mode;
        n_dot    = r_dot;
        n_cand   = r_cand;
        n_len    = r_len;
        res      = '0;
        cnt      = 3'd0;
        do_char  = 1'b0;
        do_close = 1'b0;
        do_idle  = 1'b0;

        if (i_item.kind) begin
            do_close = 1'b1;
        end else begin
            case (r_mode)
                MODE_COMMENT: begin
                    if (c == CH_NEWLINE) begin
                        n_mode = MODE_IDLE;
                    end
                end
                MODE_NUMBER: begin
                    if (c_digit) begin
                        do_char = 1'b1;
                    end else if ((c == CH_DOT) && !r_dot) begin
                        n_dot   = 1'b1;
                        do_char = 1'b1;
                    end else begin
                        do_close = 1'b1;
                        do_idle  = 1'b1;
                    end
                end
                MODE_IDENT: begin
                    if (c_word) begin
                        do_char = 1'b1;
                        n_cand  = cand_tr;
                        n_len   = len_inc;
                    end else begin
                        do_close = 1'b1;
                        do_idle  = 1'b1;
                    end
                end
                MODE_STRING: begin
                    if (c == CH_QUOTE) begin
                        do_close = 1'b1;
                    end else begin
                        do_char = 1'b1;
                    end
                end
                default: begin
                    do_idle = 1'b1;
                end
            endcase
        end

        if (do_char) begin
            case (r_mode)
                MODE_IDENT:  res[0] = mk_res(EV_CHAR, CLS_IDENT, c, 4'd0);
                MODE_STRING: res[0] = mk_res(EV_CHAR, CLS_STRING, c, 4'd0);
                default:     res[0] = mk_res(EV_CHAR, CLS_NUMBER, c, 4'd0);
            endcase
            cnt = 3'd1;
        end

        if (do_close) begin
            case (r_mode)
                MODE_NUMBER: begin
                    res[cnt[1:0]] = mk_res(EV_CLOSE, CLS_NUMBER, 8'd0, 4'd0);
                    cnt = cnt + 3'd1;
                end
                MODE_IDENT: begin
                    res[cnt[1:0]] = mk_res(EV_CLOSE, (kw_id != 4'd0) ? CLS_KEYWORD : CLS_IDENT,
                                           8'd0, kw_id);
                    cnt = cnt + 3'd1;
                end
                MODE_STRING: begin
                    res[cnt[1:0]] = mk_res(EV_CLOSE, CLS_STRING, 8'd0, 4'd0);
                    cnt = cnt + 3'd1;
                end
                default: begin
                end
            endcase
            n_mode = MODE_IDLE;
            n_dot  = 1'b0;
        end

        if (do_idle) begin
            n_mode = MODE_IDLE;
            if (c_space) begin
            end else if (c == CH_HASH) begin
                n_mode = MODE_COMMENT;
            end else if (c_digit || (c == CH_DOT)) begin
                n_dot = (c == CH_DOT);
                res[cnt[1:0]] = mk_res(EV_OPEN, CLS_NUMBER, 8'd0, 4'd0);
                cnt = cnt + 3'd1;
                res[cnt[1:0]] = mk_res(EV_CHAR, CLS_NUMBER, c, 4'd0);
                cnt = cnt + 3'd1;
                n_mode = MODE_NUMBER;
            end else if (c_word) begin
                n_cand = cand_first;
                n_len  = 4'd1;
                res[cnt[1:0]] = mk_res(EV_OPEN, CLS_IDENT, 8'd0, 4'd0);
                cnt = cnt + 3'd1;
                res[cnt[1:0]] = mk_res(EV_CHAR, CLS_IDENT, c, 4'd0);
                cnt = cnt + 3'd1;
                n_mode = MODE_IDENT;
            end else if (c == CH_QUOTE) begin
                res[cnt[1:0]] = mk_res(EV_OPEN, CLS_STRING, 8'd0, 4'd0);
                cnt = cnt + 3'd1;
                n_mode = MODE_STRING;
            end else if (c_oper || (c == CH_SEMI)) begin
                res[cnt[1:0]] = mk_res(EV_OPEN, (c == CH_SEMI) ? CLS_PUNCT : CLS_OPER,
                                       8'd0, 4'd0);
                cnt = cnt + 3'd1;
                res[cnt[1:0]] = mk_res(EV_CHAR, (c == CH_SEMI) ? CLS_PUNCT : CLS_OPER,
                                       c, 4'd0);
                cnt = cnt + 3'd1;
                res[cnt[1:0]] = mk_res(EV_CLOSE, (c == CH_SEMI) ? CLS_PUNCT : CLS_OPER,
                                       8'd0, 4'd0);
                cnt = cnt + 3'd1;
            end
        end

        if (i_item.kind) begin
            res[cnt[1:0]] = mk_res(EV_EOF, CLS_NUMBER, 8'd0, 4'd0);
            cnt = cnt + 3'd1;
            n_mode = MODE_IDLE;
            n_dot  = 1'b0;
            n_cand = '1;
            n_len  = 4'd0;
        end

        if (cnt != 3'd0) begin
            res[2'(cnt - 3'd1)].last_of_run = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_dot  <= 1'b0;
            r_cand <= '1;
            r_len  <= 4'd0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_dot  <= n_dot;
            r_cand <= n_cand;
            r_len  <= n_len;
        end
    end

    assign o_push            = i_accept && (cnt != 3'd0);
    assign o_bundle.res      = res;
    assign o_bundle.last_idx = 2'(cnt - 3'd1);

endmodule

`default_nettype wire

// ===== rtl/core/stok_queue.sv =====
// Short queue of result bundles between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module stok_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire stok_pkg::t_bundle i_bundle,
    input  wire logic             i_pop,
    output logic                  o_full,
    output logic                  o_empty,
    output stok_pkg::t_bundle     o_head
);
    import stok_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

    t_bundle r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [PTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (PTR_W + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/stok_back.sv =====
// Back end: sends the results of each bundle one per transfer through an output register.
`timescale 1ns / 1ps
`default_nettype none

module stok_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_empty,
    input  wire stok_pkg::t_bundle i_head,
    output logic                   o_pop,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output stok_pkg::t_out_item    o_out_item
);
    import stok_pkg::*;

    logic      r_valid;
    t_out_item r_item;
    logic [1:0] r_idx;
    logic      load;

    assign load        = !i_empty && (!r_valid || i_out_ready);
    assign o_pop       = load && (r_idx == i_head.last_idx);
    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_head.res[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= o_pop ? 2'd0 : r_idx + 2'd1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/stok_checker.sv =====
// Port-level checks for the script tokenizer and their attachment to the top level.
`timescale 1ns / 1ps
`default_nettype none

module stok_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_ready,
    input wire stok_pkg::t_in_item  i_in_item,
    input wire logic                o_out_valid,
    input wire logic                i_out_ready,
    input wire stok_pkg::t_out_item o_out_item
);
    import stok_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("output transfer changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.event_res == EV_EOF) |->
            o_out_item.last_of_run && (o_out_item.token_class == CLS_NUMBER))
        else $error("end of file is not the last result of its byte");

    a_char_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.event_res != EV_CHAR) |-> o_out_item.out_char == 8'd0)
        else $error("character on a non-character event");

    a_kw_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.keyword_id != 4'd0) |->
            (o_out_item.event_res == EV_CLOSE) && (o_out_item.token_class == CLS_KEYWORD))
        else $error("keyword id outside a keyword close");

endmodule

bind script_tokenizer stok_checker u_stok_checker (.*);

`default_nettype wire
